/* rtl/rcpc_pkg.sv */
// ----------------------------------------------------------------------------
// rcpc_pkg: shared definitions for the RC pulse capture block
// Reset values, register indexes, shared-unit operation codes and the
// result item layout.
// ----------------------------------------------------------------------------
package rcpc_pkg;

   localparam int CHANNELS_DEF = 6;
   localparam int LEVELS_W     = 6;
   localparam int TIME_W       = 16;
   localparam int CHAN_W       = 4;
   localparam int ALIVE_W      = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FAIL_SAFE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_PERIOD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ALIVE_LIMIT  = 3'd5;

   // Reset values.
   localparam logic [15:0] RANGE_LOW_RST    = 16'd900;
   localparam logic [15:0] RANGE_HIGH_RST   = 16'd2100;
   localparam logic [15:0] CENTER_RST       = 16'd1500;
   localparam logic [15:0] VALUE_RST        = 16'd1500;
   localparam logic [15:0] SEEN_MIN_RST     = 16'd1200;
   localparam logic [15:0] SEEN_MAX_RST     = 16'd1800;
   localparam logic        FAIL_SAFE_RST    = 1'b1;
   localparam logic [7:0]  CHECK_PERIOD_RST = 8'd20;
   localparam logic [6:0]  ALIVE_LIMIT_RST  = 7'd20;

   // Shared arithmetic unit operations.
   typedef logic alu_op_type;
   localparam alu_op_type ALU_SUB    = 1'b0; // a - b, wrapped, with a < b flag
   localparam alu_op_type ALU_MIRROR = 1'b1; // saturate(2a - b) to 0..65535

   typedef struct packed {
      logic [TIME_W-1:0] value;
      logic              lt;
   } alu_res_type;

   typedef struct packed {
      logic                      kind;
      logic [CHAN_W-1:0]         channel;
      logic [TIME_W-1:0]         pulse_width;
      logic                      in_range;
      logic [TIME_W-1:0]         held_value;
      logic [TIME_W-1:0]         spread_low;
      logic [TIME_W-1:0]         spread_high;
      logic [ALIVE_W-1:0]        alive_level;
      logic                      signal_ok;
      logic                      last;
   } rsp_type;

endpackage

/* rtl/rcpc_if.sv */
// ----------------------------------------------------------------------------
// rcpc_if: channel interfaces of the RC pulse capture block
// Input sample channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rcpc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [5:0]  levels;
   logic [15:0] timestamp;

   modport source (output valid, opcode, levels, timestamp, input ready);
   modport sink   (input valid, opcode, levels, timestamp, output ready);
endinterface

interface rcpc_rsp_if;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [3:0]        channel;
   logic [15:0]       pulse_width;
   logic              in_range;
   logic [15:0]       held_value;
   logic [15:0]       spread_low;
   logic [15:0]       spread_high;
   logic signed [7:0] alive_level;
   logic              signal_ok;
   logic              last;

   modport source (output valid, kind, channel, pulse_width, in_range, held_value,
                   spread_low, spread_high, alive_level, signal_ok, last,
                   input ready);
   modport sink   (input valid, kind, channel, pulse_width, in_range, held_value,
                   spread_low, spread_high, alive_level, signal_ok, last,
                   output ready);
endinterface

interface rcpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rc_pulse_capture_failsafe.sv */
// ----------------------------------------------------------------------------
// rc_pulse_capture_failsafe: servo pulse capture with signal-loss failsafe
// Measures receiver pulse widths per channel, tracks value and spread, and
// runs a periodic alive check driven by timer ticks.
// ----------------------------------------------------------------------------
// Usage:
// An item on req_ch is either a pin sample (opcode 0: channel levels plus a
// microsecond timestamp) or a millisecond timer tick (opcode 1). req_ch is
// ready only while the sequencer is idle; one item is worked on at a time.
// A tick gives exactly one status item, which the tick state loads into the
// output register once that register is free. A pin sample walks the
// channels in order, one per cycle for each channel without a falling edge.
// Each channel with a falling edge then goes through the shared
// subtract/mirror unit: when its width is in range through width, two bound
// checks, min, max, two mirror/compare pairs and the hand-over, and when it
// is not through width, two bound checks and the hand-over; it gives one item.
// The last item of a sample or tick has last set; a sample without a falling
// edge gives no item. rsp_ch has a one-entry output register; when the
// receiver stalls the sequencer waits at the point where it would hand over
// the next item. csr_ch is always ready; registers are meant to be written
// while idle. Reset (synchronous, active high) restores register defaults,
// centers every channel value, resets the spread and clears the alive state.
// ----------------------------------------------------------------------------
module rc_pulse_capture_failsafe import rcpc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rcpc_req_if.sink    req_ch,
   rcpc_rsp_if.source  rsp_ch,
   rcpc_csr_if.sink    csr_ch
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_TICK  = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_WIDTH = 4'd3;
   localparam logic [3:0] ST_LOCHK = 4'd4;
   localparam logic [3:0] ST_HICHK = 4'd5;
   localparam logic [3:0] ST_MIN   = 4'd6;
   localparam logic [3:0] ST_MAX   = 4'd7;
   localparam logic [3:0] ST_MIR1  = 4'd8;
   localparam logic [3:0] ST_CMP1  = 4'd9;
   localparam logic [3:0] ST_MIR2  = 4'd10;
   localparam logic [3:0] ST_CMP2  = 4'd11;
   localparam logic [3:0] ST_EMIT  = 4'd12;

   // Configuration registers.
   logic [15:0] range_low_ff, range_high_ff, center_ff;
   logic        fail_safe_ff;
   logic [7:0]  period_ff;
   logic [6:0]  limit_ff;

   // Control and channel state.
   logic [3:0]          state_ff, state_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [CHANNELS-1:0] prev_ff, prev_in;
   logic [CHANNELS-1:0] now_ff, now_in;
   logic [CHANNELS-1:0] chg_ff, chg_in;
   logic [CHANNELS-1:0] fall_ff, fall_in;
   logic [CHANNELS-1:0] seen_ff, seen_in;
   logic [7:0]          alive_ff, alive_in;
   logic [7:0]          tick_ff, tick_in;
   logic [15:0]         rise_ff  [CHANNELS];
   logic [15:0]         rise_in  [CHANNELS];
   logic [15:0]         value_ff [CHANNELS];
   logic [15:0]         value_in [CHANNELS];
   logic [15:0]         min_ff   [CHANNELS];
   logic [15:0]         min_in   [CHANNELS];
   logic [15:0]         max_ff   [CHANNELS];
   logic [15:0]         max_in   [CHANNELS];

   // Working registers of the channel being measured.
   logic [15:0] ts_ff, ts_in;
   logic [15:0] d_ff, d_in;
   logic [15:0] m_ff, m_in;
   logic [15:0] cmin_ff, cmin_in;
   logic [15:0] cmax_ff, cmax_in;
   logic        lo_ok_ff, lo_ok_in;
   logic        inr_ff, inr_in;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Shared unit.
   alu_op_type  alu_op;
   logic [15:0] alu_a, alu_b;
   alu_res_type alu_res;

   logic [CHANNELS+LEVELS_W-1:0] lvl_pad;
   logic [CHANNELS-1:0]          lvl_now;
   logic [CHANNELS-1:0]          fall_rest;
   logic                         out_free;
   logic                         advance;
   logic [8:0]                   asum;
   logic [7:0]                   aclamp;

   rcpc_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // Channels past the levels field read as low.
   assign lvl_pad = (CHANNELS + LEVELS_W)'(req_ch.levels);
   assign lvl_now = lvl_pad[CHANNELS-1:0];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_data_ff.kind;
   assign rsp_ch.channel     = rsp_data_ff.channel;
   assign rsp_ch.pulse_width = rsp_data_ff.pulse_width;
   assign rsp_ch.in_range    = rsp_data_ff.in_range;
   assign rsp_ch.held_value  = rsp_data_ff.held_value;
   assign rsp_ch.spread_low  = rsp_data_ff.spread_low;
   assign rsp_ch.spread_high = rsp_data_ff.spread_high;
   assign rsp_ch.alive_level = $signed(rsp_data_ff.alive_level);
   assign rsp_ch.signal_ok   = rsp_data_ff.signal_ok;
   assign rsp_ch.last        = rsp_data_ff.last;

   // Operand selection for the shared unit, one operation per state.
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = d_ff;
      alu_b  = cmin_ff;
      case (state_ff)
         ST_WIDTH: begin
            alu_a = ts_ff;
            alu_b = rise_ff[ch_ff];
         end
         ST_LOCHK: begin
            alu_a = range_low_ff;
            alu_b = d_ff;
         end
         ST_HICHK: begin
            alu_a = d_ff;
            alu_b = range_high_ff;
         end
         ST_MIN: begin
            alu_a = d_ff;
            alu_b = cmin_ff;
         end
         ST_MAX: begin
            alu_a = cmax_ff;
            alu_b = d_ff;
         end
         ST_MIR1: begin
            alu_op = ALU_MIRROR;
            alu_a  = center_ff;
            alu_b  = cmax_ff;
         end
         ST_CMP1: begin
            alu_a = m_ff;
            alu_b = cmin_ff;
         end
         ST_MIR2: begin
            alu_op = ALU_MIRROR;
            alu_a  = center_ff;
            alu_b  = cmin_ff;
         end
         ST_CMP2: begin
            alu_a = cmax_ff;
            alu_b = m_ff;
         end
         default: begin
            alu_op = ALU_SUB;
         end
      endcase
   end

   // Alive counter step: one up when any channel pulsed, else one down,
   // clamped symmetrically to the configured limit.
   always_comb begin
      asum = {alive_ff[7], alive_ff} + ((|seen_ff) ? 9'd1 : 9'h1FF);
      if ($signed(asum) > $signed({2'b00, limit_ff})) begin
         aclamp = {1'b0, limit_ff};
      end else if ($signed(asum) < -$signed({2'b00, limit_ff})) begin
         aclamp = 8'd0 - {1'b0, limit_ff};
      end else begin
         aclamp = asum[7:0];
      end
   end

   always_comb begin
      fall_rest        = fall_ff;
      fall_rest[ch_ff] = 1'b0;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      prev_in      = prev_ff;
      now_in       = now_ff;
      chg_in       = chg_ff;
      fall_in      = fall_ff;
      seen_in      = seen_ff;
      alive_in     = alive_ff;
      tick_in      = tick_ff;
      rise_in      = rise_ff;
      value_in     = value_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      ts_in        = ts_ff;
      d_in         = d_ff;
      m_in         = m_ff;
      cmin_in      = cmin_ff;
      cmax_in      = cmax_ff;
      lo_ok_in     = lo_ok_ff;
      inr_in       = inr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      advance      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.opcode) begin
                  state_in = ST_TICK;
               end else begin
                  now_in   = lvl_now;
                  chg_in   = lvl_now ^ prev_ff;
                  fall_in  = (lvl_now ^ prev_ff) & ~lvl_now;
                  prev_in  = lvl_now;
                  ts_in    = req_ch.timestamp;
                  ch_in    = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_TICK: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.kind        = 1'b1;
               rsp_data_in.last        = 1'b1;
               rsp_data_in.alive_level = alive_ff;
               rsp_data_in.signal_ok   = !alive_ff[7] && (alive_ff != 8'd0);
               if (tick_ff < period_ff) begin
                  tick_in = tick_ff + 8'd1;
               end else begin
                  tick_in  = '0;
                  alive_in = aclamp;
                  seen_in  = '0;
                  rsp_data_in.alive_level = aclamp;
                  rsp_data_in.signal_ok   = !aclamp[7] && (aclamp != 8'd0);
                  if ((aclamp[7] || aclamp == 8'd0) && fail_safe_ff) begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        value_in[i] = center_ff;
                     end
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (chg_ff[ch_ff] && now_ff[ch_ff]) begin
               rise_in[ch_ff] = ts_ff;
               advance        = 1'b1;
            end else if (chg_ff[ch_ff]) begin
               cmin_in  = min_ff[ch_ff];
               cmax_in  = max_ff[ch_ff];
               state_in = ST_WIDTH;
            end else begin
               advance = 1'b1;
            end
         end
         ST_WIDTH: begin
            d_in     = alu_res.value;
            state_in = ST_LOCHK;
         end
         ST_LOCHK: begin
            lo_ok_in = alu_res.lt;
            state_in = ST_HICHK;
         end
         ST_HICHK: begin
            inr_in = lo_ok_ff && alu_res.lt;
            if (lo_ok_ff && alu_res.lt) begin
               value_in[ch_ff] = d_ff;
               state_in        = ST_MIN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MIN: begin
            if (alu_res.lt) begin
               cmin_in = d_ff;
            end
            state_in = ST_MAX;
         end
         ST_MAX: begin
            if (alu_res.lt) begin
               cmax_in = d_ff;
            end
            state_in = ST_MIR1;
         end
         ST_MIR1: begin
            m_in     = alu_res.value;
            state_in = ST_CMP1;
         end
         ST_CMP1: begin
            if (alu_res.lt) begin
               cmin_in = m_ff;
            end
            state_in = ST_MIR2;
         end
         ST_MIR2: begin
            m_in     = alu_res.value;
            state_in = ST_CMP2;
         end
         ST_CMP2: begin
            if (alu_res.lt) begin
               cmax_in = m_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = 1'b0;
               rsp_data_in.channel     = CHAN_W'(ch_ff);
               rsp_data_in.pulse_width = d_ff;
               rsp_data_in.in_range    = inr_ff;
               rsp_data_in.held_value  = value_ff[ch_ff];
               rsp_data_in.spread_low  = cmin_ff;
               rsp_data_in.spread_high = cmax_ff;
               rsp_data_in.alive_level = alive_ff;
               rsp_data_in.signal_ok   = !alive_ff[7] && (alive_ff != 8'd0);
               rsp_data_in.last        = (fall_rest == '0);
               min_in[ch_ff]  = cmin_ff;
               max_in[ch_ff]  = cmax_ff;
               seen_in[ch_ff] = 1'b1;
               fall_in        = fall_rest;
               advance        = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (ch_ff == CH_LAST) begin
            state_in = ST_IDLE;
         end else begin
            ch_in    = ch_ff + 1'b1;
            state_in = ST_SCAN;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RST;
         range_high_ff <= RANGE_HIGH_RST;
         center_ff     <= CENTER_RST;
         fail_safe_ff  <= FAIL_SAFE_RST;
         period_ff     <= CHECK_PERIOD_RST;
         limit_ff      <= ALIVE_LIMIT_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_RANGE_LOW:    range_low_ff  <= csr_ch.data;
            REG_RANGE_HIGH:   range_high_ff <= csr_ch.data;
            REG_CENTER_WIDTH: center_ff     <= csr_ch.data;
            REG_FAIL_SAFE:    fail_safe_ff  <= csr_ch.data[0];
            REG_CHECK_PERIOD: period_ff     <= csr_ch.data[7:0];
            REG_ALIVE_LIMIT:  limit_ff      <= csr_ch.data[6:0];
            default: begin
            end
         endcase
      end
   end

   // Control and channel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         prev_ff      <= '0;
         fall_ff      <= '0;
         seen_ff      <= '0;
         alive_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i]  <= '0;
            value_ff[i] <= VALUE_RST;
            min_ff[i]   <= SEEN_MIN_RST;
            max_ff[i]   <= SEEN_MAX_RST;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         prev_ff      <= prev_in;
         fall_ff      <= fall_in;
         seen_ff      <= seen_in;
         alive_ff     <= alive_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         rise_ff      <= rise_in;
         value_ff     <= value_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      chg_ff      <= chg_in;
      ts_ff       <= ts_in;
      d_ff        <= d_in;
      m_ff        <= m_in;
      cmin_ff     <= cmin_in;
      cmax_ff     <= cmax_in;
      lo_ok_ff    <= lo_ok_in;
      inr_ff      <= inr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/rcpc_alu.sv */
// ----------------------------------------------------------------------------
// rcpc_alu: shared subtract and mirror unit
// One 18-bit subtractor that serves width measurement, bound checks and
// the saturated mirror of the spread about the center.
// ----------------------------------------------------------------------------
module rcpc_alu import rcpc_pkg::*; (
   input  alu_op_type        op,
   input  logic [TIME_W-1:0] a,
   input  logic [TIME_W-1:0] b,
   output alu_res_type       res
);

   logic [TIME_W+1:0] opa;
   logic [TIME_W+1:0] diff;

   always_comb begin
      // The mirror works on twice the center, so the minuend is shifted.
      if (op == ALU_MIRROR) begin
         opa = {1'b0, a, 1'b0};
      end else begin
         opa = {2'b00, a};
      end
      diff = opa - {2'b00, b};
      res.lt = diff[TIME_W+1];
      if (op == ALU_MIRROR) begin
         if (diff[TIME_W+1]) begin
            res.value = '0;
         end else if (diff[TIME_W]) begin
            res.value = '1;
         end else begin
            res.value = diff[TIME_W-1:0];
         end
      end else begin
         res.value = diff[TIME_W-1:0];
      end
   end

endmodule

/* verif/rc_pulse_capture_failsafe_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_capture_failsafe_tb: self-checking bench for the RC pulse capture
// Runs directed pulse widths around the range bounds, then random receiver
// frames and timer ticks under several register settings. Each accepted item
// is predicted here, and every result item is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module rc_pulse_capture_failsafe_tb;
   import rcpc_pkg::*;

   localparam int CHANNELS     = CHANNELS_DEF;
   // Enough for a sample without a falling edge to finish its channel walk.
   localparam int SETTLE_CYCLES = 20;
   // Worst case is far below this: six stalled results per sample at most.
   localparam int CYCLE_LIMIT  = 400000;

   // Input opcodes and result kinds.
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_TICK      = 1'b1;
   localparam logic KIND_PULSE   = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // The plan is a script of bus actions: input items, register writes,
   // changes of the idle pattern and waits for the block to go idle.
   typedef enum logic [1:0] {ACT_ITEM, ACT_CSR, ACT_MODE, ACT_SETTLE} act_kind_type;

   typedef struct packed {
      act_kind_type          kind;
      logic                  opcode;
      logic [LEVELS_W-1:0]   levels;
      logic [TIME_W-1:0]     stamp;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      logic [6:0]            send_pct;
      logic [6:0]            recv_pct;
   } plan_entry_type;

   logic clock;
   logic reset;

   rcpc_req_if req_ch ();
   rcpc_rsp_if rsp_ch ();
   rcpc_csr_if csr_ch ();

   rc_pulse_capture_failsafe #(.CHANNELS(CHANNELS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   plan_entry_type plan_q[$];
   rsp_type        report_q[$];

   int fail_cnt      = 0;
   int cycle_cnt     = 0;
   int settle_cnt    = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Stimulus shaping: the last levels placed in the plan and a running clock.
   logic [LEVELS_W-1:0] gen_levels = '0;
   logic [TIME_W-1:0]   gen_time   = '0;

   // Predicted register contents.
   logic [15:0] cfg_range_low;
   logic [15:0] cfg_range_high;
   logic [15:0] cfg_center;
   logic        cfg_fail_safe;
   logic [7:0]  cfg_check_period;
   logic [6:0]  cfg_alive_limit;

   // Predicted channel state.
   logic [LEVELS_W-1:0] last_levels;
   logic [15:0]         rise_stamp  [CHANNELS];
   logic [15:0]         held_width  [CHANNELS];
   logic [15:0]         spread_min  [CHANNELS];
   logic [15:0]         spread_max  [CHANNELS];
   logic [CHANNELS-1:0] pulse_marks;
   int                  alive_level;
   int                  tick_cnt;

   // -------------------------------------------------------------------------
   // Clock and reset. Inputs take their idle values in the driver and the
   // monitor while reset is high.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor.
   // -------------------------------------------------------------------------
   function automatic logic [15:0] clamp_width(input int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   task automatic clear_prediction();
      cfg_range_low    = RANGE_LOW_RST;
      cfg_range_high   = RANGE_HIGH_RST;
      cfg_center       = CENTER_RST;
      cfg_fail_safe    = FAIL_SAFE_RST;
      cfg_check_period = CHECK_PERIOD_RST;
      cfg_alive_limit  = ALIVE_LIMIT_RST;
      last_levels      = '0;
      pulse_marks      = '0;
      alive_level      = 0;
      tick_cnt         = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         rise_stamp[i] = '0;
         held_width[i] = VALUE_RST;
         spread_min[i] = SEEN_MIN_RST;
         spread_max[i] = SEEN_MAX_RST;
      end
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_RANGE_LOW:    cfg_range_low    = data;
         REG_RANGE_HIGH:   cfg_range_high   = data;
         REG_CENTER_WIDTH: cfg_center       = data;
         REG_FAIL_SAFE:    cfg_fail_safe    = data[0];
         REG_CHECK_PERIOD: cfg_check_period = data[7:0];
         REG_ALIVE_LIMIT:  cfg_alive_limit  = data[6:0];
         default: ;
      endcase
   endtask

   // Works out the result items of one accepted input item and queues them.
   task automatic predict_reports(input logic opcode, input logic [LEVELS_W-1:0] levels,
                                  input logic [TIME_W-1:0] stamp);
      rsp_type             rep;
      logic [LEVELS_W-1:0] changed;
      logic [15:0]         width;
      logic [15:0]         mirror;
      int                  center;
      int                  lim;
      int                  queued;
      center = int'(cfg_center);
      lim    = int'(cfg_alive_limit);
      queued = report_q.size();
      if (opcode == OP_TICK) begin
         if (tick_cnt < int'(cfg_check_period)) begin
            tick_cnt++;
         end else begin
            // Alive check: step the counter, clamp it, and center on loss.
            tick_cnt = 0;
            alive_level += (pulse_marks != '0) ? 1 : -1;
            if (alive_level > lim) alive_level = lim;
            if (alive_level < -lim) alive_level = -lim;
            if (alive_level <= 0 && cfg_fail_safe) begin
               for (int i = 0; i < CHANNELS; i++) held_width[i] = cfg_center;
            end
            pulse_marks = '0;
         end
         rep = '0;
         rep.kind        = KIND_STATUS;
         rep.alive_level = alive_level[7:0];
         rep.signal_ok   = (alive_level > 0);
         rep.last        = 1'b1;
         report_q.push_back(rep);
      end else begin
         changed = levels ^ last_levels;
         for (int i = 0; i < CHANNELS; i++) begin
            if (changed[i]) begin
               if (levels[i]) begin
                  rise_stamp[i] = stamp;
               end else begin
                  width = stamp - rise_stamp[i];
                  rep = '0;
                  if (cfg_range_low < width && width < cfg_range_high) begin
                     rep.in_range  = 1'b1;
                     held_width[i] = width;
                     if (width < spread_min[i]) spread_min[i] = width;
                     if (width > spread_max[i]) spread_max[i] = width;
                     // The spread is kept symmetric about the center width.
                     mirror = clamp_width(2 * center - int'(spread_max[i]));
                     if (mirror < spread_min[i]) spread_min[i] = mirror;
                     mirror = clamp_width(2 * center - int'(spread_min[i]));
                     if (mirror > spread_max[i]) spread_max[i] = mirror;
                  end
                  pulse_marks[i]  = 1'b1;
                  rep.kind        = KIND_PULSE;
                  rep.channel     = 4'(i);
                  rep.pulse_width = width;
                  rep.held_value  = held_width[i];
                  rep.spread_low  = spread_min[i];
                  rep.spread_high = spread_max[i];
                  rep.alive_level = alive_level[7:0];
                  rep.signal_ok   = (alive_level > 0);
                  report_q.push_back(rep);
               end
            end
         end
         last_levels = levels;
         if (report_q.size() > queued) report_q[report_q.size() - 1].last = 1'b1;
      end
   endtask

   // -------------------------------------------------------------------------
   // Driver: walks the plan, drives the input and register channels, and
   // feeds each accepted item to the predictor at its acceptance edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      plan_entry_type act;
      logic           req_busy;
      logic           csr_busy;
      if (reset) begin
         clear_prediction();
         req_ch.valid     <= 1'b0;
         req_ch.opcode    <= OP_SAMPLE;
         req_ch.levels    <= '0;
         req_ch.timestamp <= '0;
         csr_ch.valid     <= 1'b0;
         csr_ch.index     <= REG_RANGE_LOW;
         csr_ch.data      <= '0;
         settle_cnt = 0;
      end else begin
         req_busy = req_ch.valid;
         csr_busy = csr_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            predict_reports(req_ch.opcode, req_ch.levels, req_ch.timestamp);
            req_busy = 1'b0;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            apply_register(csr_ch.index, csr_ch.data);
            csr_busy = 1'b0;
         end
         // A new action starts only when nothing is left in flight, so a
         // valid that stays high is never lowered and raised in one step.
         if (!req_busy && !csr_busy && plan_q.size() > 0) begin
            act = plan_q[0];
            case (act.kind)
               ACT_ITEM: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     req_ch.opcode    <= act.opcode;
                     req_ch.levels    <= act.levels;
                     req_ch.timestamp <= act.stamp;
                     req_busy = 1'b1;
                     void'(plan_q.pop_front());
                  end
               end
               ACT_CSR: begin
                  csr_ch.index <= act.reg_index;
                  csr_ch.data  <= act.reg_data;
                  csr_busy = 1'b1;
                  void'(plan_q.pop_front());
               end
               ACT_MODE: begin
                  send_idle_pct  = act.send_pct;
                  recv_stall_pct = act.recv_pct;
                  void'(plan_q.pop_front());
               end
               ACT_SETTLE: begin
                  // Registers change only once the block has gone quiet: all
                  // results in, plus time for a sample that yields none.
                  if (report_q.size() == 0) begin
                     if (settle_cnt >= SETTLE_CYCLES) begin
                        settle_cnt = 0;
                        void'(plan_q.pop_front());
                     end else begin
                        settle_cnt++;
                     end
                  end else begin
                     settle_cnt = 0;
                  end
               end
               default: void'(plan_q.pop_front());
            endcase
         end
         req_ch.valid <= req_busy;
         csr_ch.valid <= csr_busy;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: random back-pressure and a field-by-field check of each item.
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (report_q.size() == 0) begin
               $error("result item with no prediction waiting");
               fail_cnt++;
            end else begin
               want = report_q.pop_front();
               check_field("kind",        want.kind,        rsp_ch.kind);
               check_field("channel",     want.channel,     rsp_ch.channel);
               check_field("pulse_width", want.pulse_width, rsp_ch.pulse_width);
               check_field("in_range",    want.in_range,    rsp_ch.in_range);
               check_field("held_value",  want.held_value,  rsp_ch.held_value);
               check_field("spread_low",  want.spread_low,  rsp_ch.spread_low);
               check_field("spread_high", want.spread_high, rsp_ch.spread_high);
               check_field("alive_level", $signed(want.alive_level), rsp_ch.alive_level);
               check_field("signal_ok",   want.signal_ok,   rsp_ch.signal_ok);
               check_field("last",        want.last,        rsp_ch.last);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("[rc_pulse_capture_failsafe] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Plan building.
   // -------------------------------------------------------------------------
   task automatic plan_sample(input logic [LEVELS_W-1:0] levels, input logic [15:0] stamp);
      plan_entry_type act;
      act = '0;
      act.kind   = ACT_ITEM;
      act.opcode = OP_SAMPLE;
      act.levels = levels;
      act.stamp  = stamp;
      plan_q.push_back(act);
      gen_levels = levels;
   endtask

   task automatic plan_tick();
      plan_entry_type act;
      act = '0;
      act.kind   = ACT_ITEM;
      act.opcode = OP_TICK;
      // The timestamp of a tick is ignored, so it carries noise.
      act.levels = 6'($urandom());
      act.stamp  = 16'($urandom());
      plan_q.push_back(act);
   endtask

   task automatic plan_mode(input int send_pct, input int recv_pct);
      plan_entry_type act;
      act = '0;
      act.kind     = ACT_MODE;
      act.send_pct = 7'(send_pct);
      act.recv_pct = 7'(recv_pct);
      plan_q.push_back(act);
   endtask

   task automatic plan_settle();
      plan_entry_type act;
      act = '0;
      act.kind = ACT_SETTLE;
      plan_q.push_back(act);
   endtask

   task automatic plan_write(input logic [CSR_IDX_W-1:0] index, input logic [15:0] data);
      plan_entry_type act;
      act = '0;
      act.kind      = ACT_CSR;
      act.reg_index = index;
      act.reg_data  = data;
      plan_q.push_back(act);
   endtask

   task automatic plan_setting(input logic [15:0] low, input logic [15:0] high,
                               input logic [15:0] center, input logic fail_safe,
                               input logic [7:0] period, input logic [6:0] limit);
      plan_settle();
      plan_write(REG_RANGE_LOW,    low);
      plan_write(REG_RANGE_HIGH,   high);
      plan_write(REG_CENTER_WIDTH, center);
      plan_write(REG_FAIL_SAFE,    {15'd0, fail_safe});
      plan_write(REG_CHECK_PERIOD, {8'd0, period});
      plan_write(REG_ALIVE_LIMIT,  {9'd0, limit});
   endtask

   // Random traffic: mostly receiver frames where channels rise and fall a
   // few hundred microseconds apart, so widths land on both sides of the
   // range bounds; the rest is ticks and samples with random content.
   task automatic plan_traffic(input int count);
      int                  roll;
      logic [LEVELS_W-1:0] falling;
      logic [LEVELS_W-1:0] rising;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 22) begin
            plan_tick();
         end else if (roll < 82) begin
            gen_time += 16'($urandom_range(1300, 250));
            falling = 6'($urandom()) & gen_levels;
            rising  = 6'($urandom()) & ~gen_levels;
            plan_sample((gen_levels & ~falling) | rising, gen_time);
         end else begin
            plan_sample(6'($urandom()), 16'($urandom()));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin
      plan_mode(13, 67);

      // Directed part at reset settings: a first tick, then all channels at
      // once, widths on and next to both exclusive bounds, wrap-around of the
      // timestamp, widths of zero and of the full 16-bit span, a sample with
      // no change, and mixed rising and falling edges in one sample.
      plan_tick();
      plan_sample(6'h3F, 16'd0);
      plan_sample(6'h00, 16'd1500);
      plan_sample(6'h3F, 16'd64636);
      plan_sample(6'h3E, 16'd0);       // channel 0: exactly the lower bound
      plan_sample(6'h3C, 16'd1);       // channel 1: just above it
      plan_sample(6'h38, 16'd1199);    // channel 2: just below the upper bound
      plan_sample(6'h30, 16'd1200);    // channel 3: exactly the upper bound
      plan_sample(6'h00, 16'd64636);   // channels 4 and 5: zero width
      plan_sample(6'h01, 16'd1);
      plan_sample(6'h00, 16'd0);       // full-span width
      plan_sample(6'h00, 16'hFFFF);    // no edge, no result
      plan_sample(6'h2A, 16'd300);
      plan_sample(6'h15, 16'd1900);
      plan_sample(6'h00, 16'd2800);
      plan_sample(6'h01, 16'd3000);
      plan_sample(6'h00, 16'd4000);    // narrow pulse widens the spread both ways

      // Alive check on every tick: counter goes up, then down into failsafe.
      plan_settle();
      plan_write(REG_CHECK_PERIOD, 16'd0);
      plan_tick();
      plan_tick();
      plan_tick();
      plan_sample(6'h02, 16'd5000);
      plan_sample(6'h00, 16'd6234);
      plan_tick();
      plan_tick();

      // Widest range (only widths 0 and 65535 rejected), failsafe off, clamp at one.
      plan_setting(16'd0, 16'hFFFF, 16'd1500, 1'b0, 8'd0, 7'd1);
      plan_traffic(35);

      plan_mode(67, 13);
      // Center at the top saturates the mirrored bounds; widest clamp.
      plan_setting(16'd800, 16'd2200, 16'hFFFF, 1'b1, 8'd3, 7'd127);
      plan_traffic(35);
      // Empty range, center at zero, longest period, clamp pinned at zero.
      plan_setting(16'd1000, 16'd1001, 16'd0, 1'b1, 8'd255, 7'd0);
      plan_traffic(35);

      plan_mode(0, 0);
      plan_setting(16'd900, 16'd2100, 16'd0, 1'b1, 8'd1, 7'd5);
      plan_traffic(35);

      do @(posedge clock);
      while (plan_q.size() != 0 || req_ch.valid || csr_ch.valid || report_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (report_q.size() != 0) begin
         $error("%0d predicted result items never arrived", report_q.size());
         fail_cnt++;
      end
      if (fail_cnt == 0) begin
         $display("[rc_pulse_capture_failsafe] OK");
      end else begin
         $display("[rc_pulse_capture_failsafe] ERROR");
      end
      $finish;
   end

endmodule
